// ===== sv/plid_pkg.sv =====
`default_nettype none

package plid_pkg;

  // list size and derived widths
  localparam int CAPACITY = 64;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VAL_W    = 32;
  localparam int OP_W     = 3;
  localparam int ST_W     = 3;

  // packed stream widths, rounded up to whole bytes
  localparam int IN_DATA_W  = ((VAL_W + CNT_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((VAL_W + CNT_W + 7) / 8) * 8;

  // operation codes
  typedef enum logic [OP_W-1:0] {
    OP_LIST       = 3'd0,
    OP_INS_FRONT  = 3'd1,
    OP_INS_POS    = 3'd2,
    OP_INS_END    = 3'd3,
    OP_DEL_FRONT  = 3'd4,
    OP_DEL_POS    = 3'd5,
    OP_DEL_END    = 3'd6
  } op_t;

  // result status codes
  typedef enum logic [ST_W-1:0] {
    ST_OK        = 3'd0,
    ST_OVERFLOW  = 3'd1,
    ST_UNDERFLOW = 3'd2,
    ST_BAD_POS   = 3'd3,
    ST_EMPTY     = 3'd4
  } status_t;

  // where an insert or delete takes effect
  typedef enum logic [1:0] {
    IDX_ZERO = 2'd0,
    IDX_POS  = 2'd1,
    IDX_END  = 2'd2
  } idx_sel_t;

  // controller to datapath commands
  typedef struct packed {
    logic     capture;
    logic     ins;
    logic     del;
    idx_sel_t idx_sel;
    logic     load_single;
    logic     list_step;
    logic     list_emit;
    status_t  status;
  } plid_cmd_t;

  // datapath to controller status
  typedef struct packed {
    op_t  op;
    logic empty;
    logic full;
    logic pos_gt_count;
    logic pos_ge_count;
    logic k_lt_count;
    logic k_end;
  } plid_stat_t;

endpackage

`default_nettype wire

// ===== sv/plid_ctrl.sv =====
`default_nettype none

module plid_ctrl
  import plid_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  input  wire plid_stat_t stat,
  output plid_cmd_t       cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_LIST
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;
  logic   out_load;

  assign s_axis_tready = (state == S_IDLE);
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign out_load      = cmd.load_single || cmd.list_emit;

  // command decode and next state
  always_comb begin
    cmd        = '0;
    cmd.status = ST_OK;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        cmd.capture = s_axis_tvalid;
        if (s_axis_tvalid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.op == OP_LIST && !stat.empty) begin
          state_next = S_LIST;
        end else if (out_free) begin
          cmd.load_single = 1'b1;
          state_next      = S_IDLE;
          unique case (stat.op)
            OP_LIST: cmd.status = ST_EMPTY;
            OP_INS_FRONT: begin
              cmd.idx_sel = IDX_ZERO;
              if (stat.full) cmd.status = ST_OVERFLOW;
              else cmd.ins = 1'b1;
            end
            OP_INS_POS: begin
              cmd.idx_sel = IDX_POS;
              if (stat.pos_gt_count) cmd.status = ST_BAD_POS;
              else if (stat.full) cmd.status = ST_OVERFLOW;
              else cmd.ins = 1'b1;
            end
            OP_INS_END: begin
              cmd.idx_sel = IDX_END;
              if (stat.full) cmd.status = ST_OVERFLOW;
              else cmd.ins = 1'b1;
            end
            OP_DEL_FRONT: begin
              cmd.idx_sel = IDX_ZERO;
              if (stat.empty) cmd.status = ST_UNDERFLOW;
              else cmd.del = 1'b1;
            end
            OP_DEL_POS: begin
              cmd.idx_sel = IDX_POS;
              if (stat.empty) cmd.status = ST_UNDERFLOW;
              else if (stat.pos_ge_count) cmd.status = ST_BAD_POS;
              else cmd.del = 1'b1;
            end
            OP_DEL_END: begin
              cmd.idx_sel = IDX_END;
              if (stat.empty) cmd.status = ST_UNDERFLOW;
              else cmd.del = 1'b1;
            end
            default: cmd.status = ST_OK;
          endcase
        end
      end
      S_LIST: begin
        // emit while inside the list, then finish the full rotation
        if (stat.k_lt_count) begin
          if (out_free) begin
            cmd.list_step = 1'b1;
            cmd.list_emit = 1'b1;
          end
        end else begin
          cmd.list_step = 1'b1;
        end
        if (cmd.list_step && stat.k_end) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/plid_dp.sv =====
`default_nettype none

module plid_dp
  import plid_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic [OP_W-1:0]       in_op,
  input  wire logic [IN_DATA_W-1:0]  in_data,
  input  wire plid_cmd_t             cmd,
  output plid_stat_t                 stat,
  output logic [OUT_DATA_W-1:0]      out_data,
  output logic [ST_W-1:0]            out_user,
  output logic                       out_last
);

  // captured request
  op_t               op;
  logic [VAL_W-1:0]  item_value;
  logic [CNT_W-1:0]  position;

  // list state
  logic [VAL_W-1:0]  entries [CAPACITY];
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic [CNT_W-1:0]  k;
  logic [CNT_W-1:0]  idx;

  // result register
  status_t           res_status;
  logic [VAL_W-1:0]  res_element;
  logic              res_last;
  logic [CNT_W-1:0]  res_count;

  // status toward the controller
  assign stat.op           = op;
  assign stat.empty        = (count == '0);
  assign stat.full         = (count >= CNT_W'(CAPACITY));
  assign stat.pos_gt_count = (position > count);
  assign stat.pos_ge_count = (position >= count);
  assign stat.k_lt_count   = (k < count);
  assign stat.k_end        = (k == CNT_W'(CAPACITY - 1));

  // index where the change takes effect
  always_comb begin
    unique case (cmd.idx_sel)
      IDX_POS: idx = position;
      IDX_END: idx = cmd.del ? (count - CNT_W'(1)) : count;
      default: idx = '0;
    endcase
  end

  always_comb begin
    count_next = count;
    if (cmd.ins) count_next = count + CNT_W'(1);
    else if (cmd.del) count_next = count - CNT_W'(1);
  end

  // request capture, count and list counter
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      k     <= '0;
    end else begin
      count <= count_next;
      if (cmd.capture) k <= '0;
      else if (cmd.list_step) k <= k + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op         <= op_t'(in_op);
      item_value <= in_data[VAL_W-1:0];
      position   <= in_data[VAL_W +: CNT_W];
    end
  end

  // entry chain: shift up on insert, down on delete, rotate when listing
  for (genvar i = 0; i < CAPACITY; i++) begin : g_entry
    always_ff @(posedge clk) begin
      if (cmd.ins) begin
        if (CNT_W'(i) == idx) begin
          entries[i] <= item_value;
        end else if (CNT_W'(i) > idx) begin
          entries[i] <= entries[(i + CAPACITY - 1) % CAPACITY];
        end
      end else if (cmd.del) begin
        if (CNT_W'(i) >= idx && i < CAPACITY - 1) begin
          entries[i] <= entries[(i + 1) % CAPACITY];
        end
      end else if (cmd.list_step) begin
        entries[i] <= entries[(i + 1) % CAPACITY];
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load_single) begin
      res_status  <= cmd.status;
      res_element <= '0;
      res_last    <= 1'b1;
      res_count   <= count_next;
    end else if (cmd.list_emit) begin
      res_status  <= cmd.status;
      res_element <= entries[0];
      res_last    <= ((k + CNT_W'(1)) == count);
      res_count   <= count;
    end
  end

  assign out_data = {{(OUT_DATA_W - VAL_W - CNT_W){1'b0}}, res_count, res_element};
  assign out_user = res_status;
  assign out_last = res_last;

endmodule

`default_nettype wire

// ===== sv/positional_list_insert_delete_top.sv =====
// Positional list store: an ordered list of up to CAPACITY signed 32-bit
// values, driven by one request per input item on the s_axis channel.
// s_axis_tuser carries the operation (list, insert front/position/end,
// delete front/position/end); s_axis_tdata carries the value and position.
// Every request except a non-empty listing gives one result on m_axis with
// tlast high; a listing gives one result per entry in order, tlast on the
// final entry. tuser carries the status, tdata the element and the count.
// A single-result request is captured in idle and decided in the execute
// state once m_axis can take a result; its result is registered as the block
// returns to idle to take the next request, not before. Inserts and deletes
// shift the whole entry chain in parallel.
// A listing rotates the entry chain once around, one step per cycle while
// m_axis does not stall; its first result is registered from the list state
// after the execute state, and the next request is taken when the rotation
// ends and the block returns to idle. The list is back in order at its end.
// Reset empties the list. When m_axis stalls, the result register holds and
// the block waits before producing further results.
`default_nettype none

module positional_list_insert_delete_top
  import plid_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,   // item_value, position, zero fill
  input  wire logic [OP_W-1:0]       s_axis_tuser,   // operation
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,   // element, entry_count, zero fill
  output logic [ST_W-1:0]            m_axis_tuser,   // status
  output logic                       m_axis_tlast
);

  plid_cmd_t  cmd;
  plid_stat_t stat;

  plid_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .stat          (stat),
    .cmd           (cmd)
  );

  plid_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_op    (s_axis_tuser),
    .in_data  (s_axis_tdata),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (m_axis_tdata),
    .out_user (m_axis_tuser),
    .out_last (m_axis_tlast)
  );

endmodule

`default_nettype wire
